[hw/rtl/wavetable_sample_player_unit_macros.svh]
// Assertion macros used by the sample player top-level RTL.
`ifndef WAVETABLE_SAMPLE_PLAYER_UNIT_MACROS_SVH
`define WAVETABLE_SAMPLE_PLAYER_UNIT_MACROS_SVH
// Implication checked every cycle outside reset.
`define WSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define WSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hw/rtl/wsp_pkg.sv]
// Package: shared types and constants of the sample player.
package wsp_pkg;
  localparam int SampleW = 16;
  localparam int MixW    = 24;
  localparam int PosW    = 32;
  localparam int FramesW = 17;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_WAVE_FRAMES = 2'd0,
    REG_STEREO      = 2'd1,
    REG_STEP        = 2'd2,
    REG_INTERP      = 2'd3
  } reg_idx_t;

  localparam logic signed [MixW-1:0] MixMax = 24'sh7FFFFF;
  localparam logic signed [MixW-1:0] MixMin = -24'sh800000;

  // Control from the sequencer to the interpolator.
  typedef struct packed {
    logic start;   // load four neighbors for a new channel
    logic linear;  // 1 linear, 0 Hermite
  } interp_ctl_t;
endpackage

[hw/rtl/wsp_sample_mem.sv]
// Sample memory: one write port, one registered read port.
module wsp_sample_mem #(
  parameter int AddrW = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AddrW-1:0]               waddr,
  input  logic [wsp_pkg::SampleW-1:0]    wdata,
  input  logic [AddrW-1:0]               raddr,
  output logic [wsp_pkg::SampleW-1:0]    rdata
);
  import wsp_pkg::*;
  logic [SampleW-1:0] mem [2**AddrW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/wsp_interp.sv]
// Interpolator: Hermite or linear over four neighbors, one multiply per cycle.
module wsp_interp (
  input  logic                              clk,
  input  logic                              rst,
  input  wsp_pkg::interp_ctl_t              ctl,
  input  logic signed [wsp_pkg::SampleW-1:0] xm1,
  input  logic signed [wsp_pkg::SampleW-1:0] x0,
  input  logic signed [wsp_pkg::SampleW-1:0] x1,
  input  logic signed [wsp_pkg::SampleW-1:0] x2,
  input  logic [15:0]                       frac,
  output logic                              done,
  output logic signed [17:0]                result
);
  import wsp_pkg::*;

  // coefficient ranges: C 17b, V 18b, W 19b, A 21b, B 21b
  logic signed [16:0] c_q;
  logic signed [20:0] a_q, b_q;
  logic signed [15:0] x0_q, x1_q;
  logic [15:0]        f_q;
  logic               lin_q;
  logic [2:0]         phase;
  logic               busy;
  logic signed [53:0] acc;

  logic signed [16:0] c_w;
  logic signed [17:0] v_w;
  logic signed [18:0] w_w;
  logic signed [20:0] a_w, b_w;
  logic signed [16:0] f_s;
  logic signed [53:0] prod_p1, prod_p2, prod_p3, prod_l;
  logic signed [53:0] p2_w;

  assign c_w = 17'(x1) - 17'(xm1);
  assign v_w = 18'sd2 * (18'(x0) - 18'(x1));
  assign w_w = 19'(c_w) + 19'(v_w);
  assign a_w = 21'(w_w) + 21'(v_w) + (21'(x2) - 21'(x0));
  assign b_w = 21'(w_w) + a_w;
  assign f_s = {1'b0, f_q};

  // p1 = A*f - B*2^16 (fits 39 bits)
  assign prod_p1 = 54'(a_q * f_s) - (54'(b_q) <<< 16);
  // p2 = floor(p1*f/2^16) + C*2^16 ; p1 held in acc
  assign p2_w    = (54'(acc * 54'(f_s)) >>> 16) + (54'(c_q) <<< 16);
  assign prod_p2 = p2_w;
  // p3 = p2*f + x0*2^33 + 2^32
  assign prod_p3 = 54'(acc * 54'(f_s)) + (54'(x0_q) <<< 33) + (54'sd1 <<< 32);
  assign prod_l  = (54'(x0_q) <<< 16) + 54'(f_s * (17'(x1_q) - 17'(x0_q))) + 54'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        phase <= 3'd0;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (lin_q || phase == 3'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      c_q <= c_w; a_q <= a_w; b_q <= b_w;
      x0_q <= x0; x1_q <= x1; f_q <= frac; lin_q <= ctl.linear;
    end else if (busy) begin
      if (lin_q) begin
        result <= 18'(prod_l >>> 16);
      end else begin
        case (phase)
          3'd0: acc <= prod_p1;
          3'd1: acc <= prod_p2;
          default: result <= 18'(prod_p3 >>> 33);
        endcase
      end
    end
  end
endmodule

[hw/rtl/wavetable_sample_player_unit.sv]
// Wavetable sample player: sequencer, sample memory and interpolator.
// Load, start, nop and stopped tick: accept, S_ISSUE, then the output register.
// A playing tick: S_READ, S_CALC, S_ADV, S_ISSUE; four sample reads, the interpolator
//   and the position update, reads and interpolation once per channel.
// One item in flight: the next accept comes in the cycle after the result is registered;
//   a stalled output holds back the next result and, with it, the next accept.
// Reset (rst, synchronous): stopped, position 0, registers to defaults; memory undefined.
`include "wavetable_sample_player_unit_macros.svh"
module wavetable_sample_player_unit #(
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [31:0]                        cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         mode,
  input  logic [15:0]                        load_addr,
  input  logic signed [15:0]                 load_value,
  input  logic signed [23:0]                 mix_left,
  input  logic signed [23:0]                 mix_right,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [23:0]                 out_left,
  output logic signed [23:0]                 out_right,
  output logic                               is_playing
);
  import wsp_pkg::*;

  localparam int AddrW = $clog2(SAMPLE_WORDS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,  // issue four neighbor reads
    S_CALC  = 5'b00100,  // interpolator busy
    S_ADV   = 5'b01000,  // advance position
    S_ISSUE = 5'b10000   // load the output register once it is free
  } state_t;

  state_t state;

  // configuration registers
  logic [FramesW-1:0] wave_frames;
  logic               stereo;
  logic [PosW-1:0]    step_increment;
  logic               interp_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_frames    <= '0;
      stereo         <= 1'b0;
      step_increment <= 32'h0001_0000;
      interp_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WAVE_FRAMES: wave_frames    <= cfg_data[FramesW-1:0];
        REG_STEREO:      stereo         <= cfg_data[0];
        REG_STEP:        step_increment <= cfg_data;
        REG_INTERP:      interp_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // playback state
  logic [PosW-1:0] position;
  logic            active;

  // captured item
  logic signed [23:0] ml_q, mr_q;
  logic               ch;      // channel being interpolated
  logic [2:0]         rd_cnt;  // reads issued (0..4), also tracks return
  logic               rd_pend;
  logic [1:0]         rd_slot;
  logic signed [15:0] nb [4];

  // memory
  logic               mem_we;
  logic [AddrW-1:0]   mem_raddr;
  logic [15:0]        mem_rdata;
  logic               rd_ok, rd_ok_q;

  assign mem_we = in_valid && !in_stall && mode_t'(mode) == MODE_LOAD;

  wsp_sample_mem #(.AddrW(AddrW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(AddrW'(load_addr)), .wdata(load_value),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // neighbor address: frame i-1+rd_cnt
  logic [16:0] frame_i;
  logic signed [18:0] frame_n;
  logic [19:0] word_n;
  assign frame_i = {1'b0, position[31:16]};
  assign frame_n = 19'(frame_i) + 19'(rd_cnt[1:0]) - 19'sd1;
  assign word_n  = stereo ? {frame_n[18:0], ch} : {1'b0, frame_n};
  assign rd_ok   = !frame_n[18] && (frame_n < 19'(wave_frames)) &&
                   ({1'b0, word_n} < 21'(SAMPLE_WORDS));
  assign mem_raddr = word_n[AddrW-1:0];

  // interpolator
  interp_ctl_t ictl;
  logic        idone;
  logic signed [17:0] ires;

  wsp_interp u_interp (
    .clk(clk), .rst(rst), .ctl(ictl),
    .xm1(nb[0]), .x0(nb[1]), .x1(nb[2]), .x2(nb[3]),
    .frac(position[15:0]), .done(idone), .result(ires)
  );

  // output register
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  logic [32:0] next_pos;
  assign next_pos = 33'(position) + 33'(step_increment);

  function automatic logic signed [23:0] sat(input logic signed [25:0] v);
    if (v > 26'(MixMax)) return MixMax;
    if (v < 26'(MixMin)) return MixMin;
    return 24'(v);
  endfunction

  logic signed [23:0] res_l, res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      position  <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
      rd_cnt    <= '0;
      rd_pend   <= 1'b0;
      ictl      <= '0;
    end else begin
      ictl.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      rd_pend <= 1'b0;
      if (rd_pend) nb[rd_slot] <= rd_ok_q ? signed'(mem_rdata) : 16'sd0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ml_q <= mix_left; mr_q <= mix_right;
            res_l <= mix_left; res_r <= mix_right;
            if (mode_t'(mode) == MODE_START) begin
              position <= '0;
              active   <= 1'b1;
            end
            if (mode_t'(mode) == MODE_TICK && active) begin
              ch <= 1'b0; rd_cnt <= '0;
              state <= S_READ;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_READ: begin
          if (rd_cnt == 3'd4) begin
            if (!rd_pend) begin
              ictl.start  <= 1'b1;
              ictl.linear <= interp_mode;
              state <= S_CALC;
            end
          end else begin
            rd_pend <= 1'b1;
            rd_slot <= rd_cnt[1:0];
            rd_ok_q <= rd_ok;
            rd_cnt  <= rd_cnt + 3'd1;
          end
        end
        S_CALC: begin
          if (idone) begin
            if (!ch) begin
              res_l  <= sat(26'(ml_q) + 26'(ires));
              if (stereo) begin
                ch <= 1'b1; rd_cnt <= '0; state <= S_READ;
              end else begin
                res_r <= sat(26'(mr_q) + 26'(ires));
                state <= S_ADV;
              end
            end else begin
              res_r <= sat(26'(mr_q) + 26'(ires));
              state <= S_ADV;
            end
          end
        end
        S_ADV: begin
          if (next_pos > {wave_frames, 16'h0000} || next_pos[32]) begin
            position <= '0;
            active   <= 1'b0;
          end else begin
            position <= next_pos[31:0];
          end
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          if (out_free) begin
            out_left   <= res_l;
            out_right  <= res_r;
            is_playing <= active;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WSP_ASSERT_IMP(a_stall_busy, clk, rst, state != S_IDLE, in_stall, "accept while busy")
  `WSP_ASSERT_IMP(a_reads_max, clk, rst, 1'b1, rd_cnt <= 3'd4, "read count overrun")
  `WSP_ASSERT_NEXT(a_start_plays, clk, rst,
    in_valid && !in_stall && mode_t'(mode) == MODE_START, active, "start did not play")
endmodule

[tb/tb.sv]
// Testbench for the wavetable sample player: random and directed items, scoreboard check.
module tb;
  import wsp_pkg::*;

  // Item and result layouts as seen on the ports.
  typedef struct {
    mode_t              op;
    logic [15:0]        addr;
    logic signed [15:0] word;
    logic signed [23:0] mix_l;
    logic signed [23:0] mix_r;
  } mix_item_t;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic               playing;
    bit                 unknown;  // frame built from a never-written word
  } frame_out_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_WAVE_FRAMES;
  logic [31:0] cfg_data  = '0;

  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [1:0]         mode       = MODE_NOP;
  logic [15:0]        load_addr  = '0;
  logic signed [15:0] load_value = '0;
  logic signed [23:0] mix_left   = '0;
  logic signed [23:0] mix_right  = '0;

  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [23:0] out_left;
  logic signed [23:0] out_right;
  logic               is_playing;

  wavetable_sample_player_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Item stream waiting for the driver, and frames the block still owes us.
  mix_item_t  mix_items[$];
  frame_out_t frames_due[$];
  mix_item_t  cur_item;
  bit         quiet = 1'b0;  // no idling on either side (bulk memory fill)
  int         errors = 0;

  // Mirror of the player state and its registers.
  logic signed [15:0] wave_mem [65536];
  bit                 wave_set [65536];
  bit                 tap_unknown = 1'b0;
  logic [31:0]        play_pos   = '0;
  bit                 play_on    = 1'b0;
  logic [16:0]        wave_len   = '0;
  bit                 stereo_on  = 1'b0;
  logic [31:0]        step_q16   = 32'h0001_0000;
  bit                 linear_on  = 1'b0;

  // Mostly short gaps, the odd long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // Frame sample with out-of-wave neighbors reading as zero.
  function automatic longint tap(longint fr, int ch);
    longint w;
    if (fr < 0 || fr >= longint'(wave_len)) return 0;
    w = stereo_on ? fr * 2 + ch : fr;
    if (w >= 65536) return 0;
    if (!wave_set[w]) tap_unknown = 1'b1;
    return longint'(wave_mem[w]);
  endfunction

  function automatic longint interp_at(int ch);
    longint i, f, xm1, x0, x1, x2, c, v, w, a, b, p1, p2, p3;
    i   = longint'(play_pos[31:16]);
    f   = longint'(play_pos[15:0]);
    xm1 = tap(i - 1, ch);
    x0  = tap(i, ch);
    x1  = tap(i + 1, ch);
    x2  = tap(i + 2, ch);
    if (linear_on) return (x0 * 65536 + f * (x1 - x0) + 32768) >>> 16;
    // Hermite on doubled coefficients, rounded half up at the end
    c  = x1 - xm1;
    v  = 2 * (x0 - x1);
    w  = c + v;
    a  = w + v + (x2 - x0);
    b  = w + a;
    p1 = a * f - b * 65536;
    p2 = ((p1 * f) >>> 16) + c * 65536;
    p3 = p2 * f + x0 * (longint'(1) << 33);
    return (p3 + (longint'(1) << 32)) >>> 33;
  endfunction

  function automatic logic signed [23:0] clip24(longint s);
    if (s > 8388607) return MixMax;
    if (s < -8388608) return MixMin;
    return s[23:0];
  endfunction

  // Advance the player by one item and return the frame it should emit.
  function automatic frame_out_t play_item(mix_item_t it);
    frame_out_t fo;
    longint l, r, nxt;
    fo.left    = it.mix_l;
    fo.right   = it.mix_r;
    fo.unknown = 1'b0;
    case (it.op)
      MODE_LOAD: begin
        wave_mem[it.addr] = it.word;
        wave_set[it.addr] = 1'b1;
      end
      MODE_START: begin
        play_pos = '0;
        play_on  = 1'b1;
      end
      MODE_TICK: if (play_on) begin
        tap_unknown = 1'b0;
        l = interp_at(0);
        r = stereo_on ? interp_at(1) : l;
        fo.unknown = tap_unknown;
        fo.left  = clip24(longint'(it.mix_l) + l);
        fo.right = clip24(longint'(it.mix_r) + r);
        nxt = longint'(play_pos) + longint'(step_q16);
        // past the end of the wave, or out of Q16.16 range: stop
        if (nxt > (longint'(wave_len) << 16) || nxt > 64'hFFFF_FFFF) begin
          play_pos = '0;
          play_on  = 1'b0;
        end else begin
          play_pos = nxt[31:0];
        end
      end
      default: ;
    endcase
    fo.playing = play_on;
    return fo;
  endfunction

  // Driver: the expectation is computed at the edge that accepts the item.
  int src_gap = 0;
  always @(posedge clk) begin
    logic next_valid;
    mix_item_t nx;
    next_valid = in_valid;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        frames_due.push_back(play_item(cur_item));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
        end else if (mix_items.size() > 0) begin
          nx = mix_items.pop_front();
          cur_item   <= nx;
          mode       <= nx.op;
          load_addr  <= nx.addr;
          load_value <= nx.word;
          mix_left   <= nx.mix_l;
          mix_right  <= nx.mix_r;
          next_valid = 1'b1;
          src_gap <= idle_len();
        end
      end
    end
    in_valid <= next_valid;
  end

  // Monitor plus receiver stalls.
  int sink_gap = 0;
  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("result with no expected frame: left %0d right %0d", out_left, out_right);
        errors++;
      end else begin
        want = frames_due.pop_front();
        // frame read from never-written words: only the play flag is known
        if (!want.unknown && out_left !== want.left) begin
          $error("out_left expected %0d got %0d", want.left, out_left);
          errors++;
        end
        if (!want.unknown && out_right !== want.right) begin
          $error("out_right expected %0d got %0d", want.right, out_right);
          errors++;
        end
        if (is_playing !== want.playing) begin
          $error("is_playing expected %0d got %0d", want.playing, is_playing);
          errors++;
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap  <= sink_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(7) == 0) sink_gap <= idle_len();
    end
  end

  // Watchdog: cycles with no accept on either channel.
  int hung = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hung <= 0;
    end else if (hung >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      hung <= hung + 1;
    end
  end

  function automatic mix_item_t mk(mode_t op, logic [15:0] a, logic signed [15:0] w,
                                   logic signed [23:0] ml, logic signed [23:0] mr);
    mix_item_t it;
    it.op = op; it.addr = a; it.word = w; it.mix_l = ml; it.mix_r = mr;
    return it;
  endfunction

  function automatic logic signed [23:0] rand_mix();
    logic [31:0] r;
    r = $urandom;
    if (r[31]) return 24'(signed'(r[15:0]));  // near zero, leaves room for the frame
    return r[23:0];
  endfunction

  function automatic mix_item_t rand_tick();
    return mk(MODE_TICK, 16'($urandom), 16'($urandom), rand_mix(), rand_mix());
  endfunction

  // Registers change only once the block has gone quiet.
  task automatic settle();
    do @(negedge clk); while (mix_items.size() || in_valid || frames_due.size());
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_WAVE_FRAMES: wave_len  = val[16:0];
      REG_STEREO:      stereo_on = val[0];
      REG_STEP:        step_q16  = val;
      default:         linear_on = val[0];
    endcase
  endtask

  task automatic setup(logic [16:0] frames, bit st, logic [31:0] step, bit lin);
    settle();
    write_reg(REG_WAVE_FRAMES, 32'(frames));
    write_reg(REG_STEREO, 32'(st));
    write_reg(REG_STEP, step);
    write_reg(REG_INTERP, 32'(lin));
  endtask

  function automatic logic [16:0] pick_frames();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd65536;
      3: return 17'd65535;
      4: return 17'($urandom_range(65534, 40));
      default: return 17'($urandom_range(40, 2));
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      3: return $urandom;
      4: return 32'($urandom_range(3, 1));
      default: return 32'($urandom_range(32'h0004_0000, 32'h0000_2000));
    endcase
  endfunction

  initial begin
    int n, k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Fill the low words that short waves play from.
    quiet = 1'b1;
    for (int a = 0; a < 128; a++) mix_items.push_back(mk(MODE_LOAD, 16'(a), 16'($urandom),
                                                       '0, '0));
    settle();
    quiet = 1'b0;

    // Directed: full-scale alternating wave, saturation, nop, idle tick, far load.
    setup(17'd4, 1'b0, 32'h0000_8000, 1'b0);
    for (int a = 0; a < 4; a++)
      mix_items.push_back(mk(MODE_LOAD, 16'(a), a[0] ? 16'sh8000 : 16'sh7FFF, MixMax, MixMin));
    mix_items.push_back(mk(MODE_TICK, '0, '0, MixMax, MixMin));    // stopped: pass through
    mix_items.push_back(mk(MODE_NOP, 16'hFFFF, 16'sh7FFF, 24'sd5, -24'sd5));
    mix_items.push_back(mk(MODE_LOAD, 16'hFFFF, 16'sh8000, '0, '0));
    mix_items.push_back(mk(MODE_START, '0, '0, 24'sd1, 24'sd2));
    for (int t = 0; t < 10; t++)
      mix_items.push_back(mk(MODE_TICK, '0, '0, t[0] ? MixMin : MixMax, t[0] ? MixMax : MixMin));
    // Empty wave: starts, then stops after one tick.
    setup(17'd0, 1'b1, 32'h0001_0000, 1'b1);
    mix_items.push_back(mk(MODE_START, '0, '0, '0, '0));
    mix_items.push_back(mk(MODE_TICK, '0, '0, 24'sd7, -24'sd7));
    mix_items.push_back(mk(MODE_TICK, '0, '0, 24'sd7, -24'sd7));
    // Stereo linear on a short wave, right channel from the next right word.
    setup(17'd3, 1'b1, 32'h0000_C000, 1'b1);
    mix_items.push_back(mk(MODE_START, '0, '0, '0, '0));
    for (int t = 0; t < 6; t++) mix_items.push_back(rand_tick());

    // Random phases: mostly start plus a run of ticks, some loads and noise.
    for (int ph = 0; ph < 30; ph++) begin
      setup(pick_frames(), 1'($urandom), pick_step(), 1'($urandom));
      n = $urandom_range(70, 40);
      k = 0;
      mix_items.push_back(mk(MODE_START, 16'($urandom), 16'($urandom), rand_mix(), rand_mix()));
      while (k < n) begin
        case ($urandom_range(19))
          0: mix_items.push_back(mk(MODE_START, 16'($urandom), 16'($urandom),
                                    rand_mix(), rand_mix()));
          1, 2: mix_items.push_back(mk(MODE_LOAD, 16'($urandom), 16'($urandom),
                                       rand_mix(), rand_mix()));
          3: mix_items.push_back(mk(MODE_NOP, 16'($urandom), 16'($urandom),
                                    rand_mix(), rand_mix()));
          default: mix_items.push_back(rand_tick());
        endcase
        k++;
      end
    end

    settle();
    if (errors == 0 && frames_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
